@@ rtl/core/rse_pkg.sv @@
// Shared types and constants for the RPN stack evaluator.
// No dependencies; every other file refers to this package by scoped names.
package rse_pkg;

  // Default sizes handed to the top level's parameters
  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed widths of the channel payloads
  localparam int OP_W   = 2;
  localparam int NUM_W  = 32;
  localparam int CODE_W = 3;
  localparam int STAT_W = 3;
  localparam int FIN_W  = 32;

  // Token kinds
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPLY = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  // Operator codes
  localparam logic [CODE_W-1:0] OPR_ADD = 3'd0;
  localparam logic [CODE_W-1:0] OPR_SUB = 3'd1;
  localparam logic [CODE_W-1:0] OPR_MUL = 3'd2;
  localparam logic [CODE_W-1:0] OPR_DIV = 3'd3;
  localparam logic [CODE_W-1:0] OPR_REM = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_VALID      = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_MANY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ENOUGH = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [STAT_W-1:0] ST_DIV_ZERO   = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVERFLOW   = 3'd5;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_ITER,
    CS_END
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic              push_wr;
    logic              err_rec;
    logic [STAT_W-1:0] err_code;
    logic              rd_ops;
    logic              rd_base;
    logic [CODE_W-1:0] alu_code;
    logic              addsub_wr;
    logic              unit_start;
    logic              unit_wr;
    logic              drop2;
    logic              out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err_seen;
    logic full;
    logic lt2;
    logic b_zero;
    logic unit_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/rse_channels.sv @@
// Valid/ready channel interfaces for token input and result output.
// Depends on rse_pkg for payload widths.
interface rse_in_if;
  logic                             valid;
  logic                             ready;
  logic [rse_pkg::OP_W-1:0]         operation;
  logic signed [rse_pkg::NUM_W-1:0] number_value;
  logic [rse_pkg::CODE_W-1:0]       operator_code;

  modport source (output valid, output operation, output number_value,
                  output operator_code, input ready);
  modport sink   (input valid, input operation, input number_value,
                  input operator_code, output ready);
endinterface

interface rse_out_if;
  logic                             valid;
  logic                             ready;
  logic [rse_pkg::STAT_W-1:0]       status;
  logic signed [rse_pkg::FIN_W-1:0] final_value;

  modport source (output valid, output status, output final_value, input ready);
  modport sink   (input valid, input status, input final_value, output ready);
endinterface

@@ rtl/core/rse_muldiv.sv @@
// Iterative multiply / signed divide / remainder unit, one bit per cycle.
// Depends on rse_pkg for operator codes.
module rse_muldiv #(
  parameter int VALUE_WIDTH = rse_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rse_pkg::CODE_W-1:0]  code,
  input  logic [VALUE_WIDTH-1:0]      opa,
  input  logic [VALUE_WIDTH-1:0]      opb,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      result
);

  localparam int VW  = VALUE_WIDTH;
  localparam int CNW = $clog2(VW + 1);

  logic              busy_r;
  logic [CNW-1:0]    cnt_r;
  logic [VW:0]       acc_r;
  logic [VW-1:0]     x_r;
  logic [VW-1:0]     y_r;
  logic              neg_r;
  logic [rse_pkg::CODE_W-1:0] code_r;

  logic [VW-1:0] mag_a, mag_b;
  logic [VW:0]   r_shift;
  logic          r_ge;
  logic          stepping;

  assign mag_a    = opa[VW-1] ? ({VW{1'b0}} - opa) : opa;
  assign mag_b    = opb[VW-1] ? ({VW{1'b0}} - opb) : opb;
  assign r_shift  = {acc_r[VW-1:0], x_r[VW-1]};
  assign r_ge     = (r_shift >= {1'b0, y_r});
  assign stepping = busy_r && (cnt_r != '0);
  assign done     = busy_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNW'(VW);
    end else if (stepping) begin
      cnt_r <= cnt_r - CNW'(1);
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      code_r <= code;
      acc_r  <= '0;
      if (code == rse_pkg::OPR_MUL) begin
        x_r   <= opa;
        y_r   <= opb;
        neg_r <= 1'b0;
      end else begin
        x_r   <= mag_a;
        y_r   <= mag_b;
        neg_r <= (code == rse_pkg::OPR_DIV) ? (opa[VW-1] ^ opb[VW-1]) : opa[VW-1];
      end
    end else if (stepping) begin
      if (code_r == rse_pkg::OPR_MUL) begin
        // shift-add: multiplicand moves left, multiplier right
        if (y_r[0]) acc_r <= {1'b0, acc_r[VW-1:0] + x_r};
        x_r <= {x_r[VW-2:0], 1'b0};
        y_r <= {1'b0, y_r[VW-1:1]};
      end else begin
        // restoring division, quotient bits shift into x_r
        acc_r <= r_ge ? (r_shift - {1'b0, y_r}) : r_shift;
        x_r   <= {x_r[VW-2:0], r_ge};
      end
    end
  end

  always_comb begin
    if (code_r == rse_pkg::OPR_MUL) begin
      result = acc_r[VW-1:0];
    end else if (code_r == rse_pkg::OPR_DIV) begin
      result = neg_r ? ({VW{1'b0}} - x_r) : x_r;
    end else begin
      result = neg_r ? ({VW{1'b0}} - acc_r[VW-1:0]) : acc_r[VW-1:0];
    end
  end

endmodule

@@ rtl/core/rse_dpath.sv @@
// Datapath: operand stack memory, count and error record, add/sub, the
// iterative mul/div unit and the result register. Depends on rse_pkg,
// rse_channels and rse_muldiv.
module rse_dpath #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = rse_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [rse_pkg::NUM_W-1:0]  number_value,
  input  rse_pkg::dp_cmd_t                  cmd,
  output rse_pkg::dp_stat_t                 stat,
  rse_out_if.source                         out_ch
);

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  logic [VW-1:0] stack_mem [STACK_DEPTH];
  logic [VW-1:0] rda_r, rdb_r;
  logic [CW-1:0] count_r;
  logic          err_seen_r;
  logic [rse_pkg::STAT_W-1:0] err_reason_r;

  logic                             out_valid_r;
  logic [rse_pkg::STAT_W-1:0]       out_status_r;
  logic signed [rse_pkg::FIN_W-1:0] out_value_r;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [VW-1:0] push_val, addsub_res, unit_res, wr_data;
  logic [IW-1:0] wr_idx;
  logic          wr_en;
  logic          unit_done;
  logic signed [rse_pkg::FIN_W-1:0] fin_val;
  logic [rse_pkg::STAT_W-1:0]       end_status;
  logic signed [rse_pkg::FIN_W-1:0] end_value;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);

  generate
    if (VW > rse_pkg::NUM_W) begin : g_push_ext
      assign push_val = {{(VW - rse_pkg::NUM_W){number_value[rse_pkg::NUM_W-1]}},
                         number_value};
    end else begin : g_push_cut
      assign push_val = number_value[VW-1:0];
    end
    if (VW >= rse_pkg::FIN_W) begin : g_fin_cut
      assign fin_val = rda_r[rse_pkg::FIN_W-1:0];
    end else begin : g_fin_ext
      assign fin_val = {{(rse_pkg::FIN_W - VW){rda_r[VW-1]}}, rda_r};
    end
  endgenerate

  assign addsub_res = (cmd.alu_code == rse_pkg::OPR_SUB) ? (rda_r - rdb_r) : (rda_r + rdb_r);

  rse_muldiv #(.VALUE_WIDTH(VW)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.unit_start),
    .code   (cmd.alu_code),
    .opa    (rda_r),
    .opb    (rdb_r),
    .done   (unit_done),
    .result (unit_res)
  );

  // single write port: push at top, results over the lower popped slot
  always_comb begin
    wr_en   = cmd.push_wr || cmd.addsub_wr || cmd.unit_wr;
    wr_idx  = cmd.push_wr ? count_r[IW-1:0] : cnt_m2[IW-1:0];
    wr_data = cmd.push_wr ? push_val : (cmd.addsub_wr ? addsub_res : unit_res);
  end

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_ops) begin
      rda_r <= stack_mem[cnt_m2[IW-1:0]];
      rdb_r <= stack_mem[cnt_m1[IW-1:0]];
    end else if (cmd.rd_base) begin
      rda_r <= stack_mem[{IW{1'b0}}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      err_seen_r   <= 1'b0;
      err_reason_r <= '0;
    end else begin
      priority if (cmd.out_load) begin
        count_r      <= '0;
        err_seen_r   <= 1'b0;
        err_reason_r <= '0;
      end else if (cmd.push_wr) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.addsub_wr || cmd.unit_wr) begin
        count_r <= cnt_m1;
      end else if (cmd.drop2) begin
        count_r <= cnt_m2;
      end else begin
        count_r <= count_r;
      end
      if (cmd.err_rec) begin
        err_seen_r   <= 1'b1;
        err_reason_r <= cmd.err_code;
      end
    end
  end

  // end-of-expression status, in priority order
  always_comb begin
    end_value = '0;
    priority if (count_r > CW'(1)) begin
      end_status = rse_pkg::ST_TOO_MANY;
    end else if (err_seen_r) begin
      end_status = err_reason_r;
    end else if (count_r == '0) begin
      end_status = rse_pkg::ST_EMPTY;
    end else begin
      end_status = rse_pkg::ST_VALID;
      end_value  = fin_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= end_status;
      out_value_r  <= end_value;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.final_value = out_value_r;

  always_comb begin
    stat.err_seen  = err_seen_r;
    stat.full      = (count_r >= CW'(STACK_DEPTH));
    stat.lt2       = (count_r < CW'(2));
    stat.b_zero    = (rdb_r == '0);
    stat.unit_done = unit_done;
    stat.out_free  = !out_valid_r || out_ch.ready;
  end

endmodule

@@ rtl/core/rse_ctrl.sv @@
// Controller: decodes tokens, sequences operator execution and end of
// expression. Depends on rse_pkg and rse_channels.
module rse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  rse_in_if.sink             in_ch,
  input  rse_pkg::dp_stat_t  stat,
  output rse_pkg::dp_cmd_t   cmd
);

  rse_pkg::ctrl_state_t state_r, state_nxt;
  logic [rse_pkg::CODE_W-1:0] code_r;
  logic accept, code_ok, go_exec, go_end;

  assign accept  = in_ch.valid && in_ch.ready;
  assign code_ok = (in_ch.operator_code <= rse_pkg::OPR_REM);
  assign go_exec = accept && (in_ch.operation == rse_pkg::OP_APPLY) &&
                   !stat.err_seen && code_ok && !stat.lt2;
  assign go_end  = accept && (in_ch.operation == rse_pkg::OP_END);
  assign in_ch.ready = (state_r == rse_pkg::CS_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rse_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) code_r <= in_ch.operator_code;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rse_pkg::CS_IDLE: begin
        if (go_exec) state_nxt = rse_pkg::CS_EXEC;
        else if (go_end) state_nxt = rse_pkg::CS_END;
      end
      rse_pkg::CS_EXEC: begin
        if ((code_r == rse_pkg::OPR_MUL) ||
            (((code_r == rse_pkg::OPR_DIV) || (code_r == rse_pkg::OPR_REM)) &&
             !stat.b_zero)) begin
          state_nxt = rse_pkg::CS_ITER;
        end else begin
          state_nxt = rse_pkg::CS_IDLE;
        end
      end
      rse_pkg::CS_ITER: if (stat.unit_done) state_nxt = rse_pkg::CS_IDLE;
      rse_pkg::CS_END:  if (stat.out_free) state_nxt = rse_pkg::CS_IDLE;
      default:          state_nxt = rse_pkg::CS_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.alu_code = code_r;
    unique case (state_r)
      rse_pkg::CS_IDLE: begin
        if (accept) begin
          unique case (in_ch.operation)
            rse_pkg::OP_PUSH: begin
              if (!stat.err_seen) begin
                if (stat.full) begin
                  cmd.err_rec  = 1'b1;
                  cmd.err_code = rse_pkg::ST_OVERFLOW;
                end else begin
                  cmd.push_wr = 1'b1;
                end
              end
            end
            rse_pkg::OP_APPLY: begin
              if (!stat.err_seen && code_ok) begin
                if (stat.lt2) begin
                  cmd.err_rec  = 1'b1;
                  cmd.err_code = rse_pkg::ST_NOT_ENOUGH;
                end else begin
                  cmd.rd_ops = 1'b1;
                end
              end
            end
            rse_pkg::OP_END: cmd.rd_base = 1'b1;
            default: ;
          endcase
        end
      end
      rse_pkg::CS_EXEC: begin
        unique case (code_r)
          rse_pkg::OPR_ADD, rse_pkg::OPR_SUB: cmd.addsub_wr = 1'b1;
          rse_pkg::OPR_MUL: cmd.unit_start = 1'b1;
          rse_pkg::OPR_DIV, rse_pkg::OPR_REM: begin
            if (stat.b_zero) begin
              cmd.drop2    = 1'b1;
              cmd.err_rec  = 1'b1;
              cmd.err_code = rse_pkg::ST_DIV_ZERO;
            end else begin
              cmd.unit_start = 1'b1;
            end
          end
          default: ;
        endcase
      end
      rse_pkg::CS_ITER: cmd.unit_wr  = stat.unit_done;
      rse_pkg::CS_END:  cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/rpn_stack_evaluator.sv @@
// RPN stack evaluator, top level: joins controller and datapath.
// Push tokens are written on transfer; operators pass the execute state, and multiply,
// or divide/remainder by nonzero, waits in the iterate state on the one-bit-per-cycle
// shift-add / restoring-divide unit. End token: result register loaded once it is free.
// Reset (synchronous, rst_n low) clears controller, count, error record, result valid;
// the stack memory is not cleared and holds no meaning until written.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = rse_pkg::VALUE_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rse_in_if.sink     in_chan,
  rse_out_if.source  out_chan
);

  // command and status between controller and datapath
  rse_pkg::dp_cmd_t  cmd;
  rse_pkg::dp_stat_t stat;

  // Controller owns in_chan.ready: tokens transfer only while it is idle.
  rse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_chan),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath owns the stack, the error record and the result register, so a
  // finished result can wait on out_chan while later tokens are taken.
  rse_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .number_value (in_chan.number_value),
    .cmd          (cmd),
    .stat         (stat),
    .out_ch       (out_chan)
  );

  // A result appears only after the controller loads it.
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.out_load))
    else $error("result valid without load");

  // Pushes never write past the top or after an error.
  a_push_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> (!stat.full && !stat.err_seen))
    else $error("illegal push");

  // No token transfer while the iterative unit finishes.
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    stat.unit_done |-> !in_chan.ready)
    else $error("token taken while unit busy");

endmodule
